// ===== src/ert_pkg.sv =====
// Shared types and codes for the expiring resident table.
// Used by the channel interfaces, the table cells, the head logic and the top level.
`timescale 1ns / 1ps

package ert_pkg;

  localparam int unsigned CntW = 15;
  localparam int unsigned IdW = 6;
  localparam int unsigned ReqW = 3;
  localparam int unsigned CmdW = 2;

  localparam logic [CntW-1:0] ReloadRst = 15'd30;

  // Request codes.
  localparam logic [ReqW-1:0] REQ_GET = 3'd0;
  localparam logic [ReqW-1:0] REQ_TICK = 3'd1;
  localparam logic [ReqW-1:0] REQ_FLUSH_UNPINNED = 3'd2;
  localparam logic [ReqW-1:0] REQ_FLUSH_PINNED = 3'd3;
  localparam logic [ReqW-1:0] REQ_PIN = 3'd4;
  localparam logic [ReqW-1:0] REQ_CLEAR = 3'd5;
  localparam logic [ReqW-1:0] REQ_RELEASE_ALL = 3'd6;

  // Result command codes.
  localparam logic [CmdW-1:0] CMD_ACK = 2'd0;
  localparam logic [CmdW-1:0] CMD_LOAD = 2'd1;
  localparam logic [CmdW-1:0] CMD_RELEASE = 2'd2;

  typedef struct packed {
    logic            loaded;
    logic            pinned;
    logic [CntW-1:0] cnt;
  } entry_t;

endpackage

// ===== src/ert_req_if.sv =====
// Request channel: valid/ready handshake with the request type and entry id.
// Depends on ert_pkg for field widths.
`timescale 1ns / 1ps

interface ert_req_if;
  logic                     valid;
  logic                     ready;
  logic [ert_pkg::ReqW-1:0] req_type;
  logic [ert_pkg::IdW-1:0]  entry_id;

  modport source (output valid, output req_type, output entry_id, input ready);
  modport sink (input valid, input req_type, input entry_id, output ready);
endinterface

// ===== src/ert_rsp_if.sv =====
// Result channel: valid/ready handshake with command, target id and last flag.
// Depends on ert_pkg for field widths.
`timescale 1ns / 1ps

interface ert_rsp_if;
  logic                     valid;
  logic                     ready;
  logic [ert_pkg::CmdW-1:0] command;
  logic [ert_pkg::IdW-1:0]  target_id;
  logic                     last;

  modport source (output valid, output command, output target_id, output last, input ready);
  modport sink (input valid, input command, input target_id, input last, output ready);
endinterface

// ===== src/ert_cell.sv =====
// One table cell: holds the state of one entry and takes its neighbor's entry on a shift.
// Depends on ert_pkg for the entry type.
`timescale 1ns / 1ps

module ert_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  ert_pkg::entry_t entry_i,
  output ert_pkg::entry_t entry_o
);

  ert_pkg::entry_t entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;

endmodule

// ===== src/ert_head.sv =====
// Head-of-ring update: applies the current request to the entry leaving cell 0.
// Depends on ert_pkg for request codes, command codes and the entry type.
`timescale 1ns / 1ps

module ert_head (
  input  ert_pkg::entry_t             entry_i,
  input  logic [ert_pkg::ReqW-1:0]    req_type_i,
  input  logic                        hit_i,
  input  logic [ert_pkg::CntW-1:0]    reload_i,
  output ert_pkg::entry_t             entry_o,
  output logic                        emit_o,
  output logic [ert_pkg::CmdW-1:0]    cmd_o
);

  logic [ert_pkg::CntW-1:0] dec;
  logic                     stale;

  assign dec = entry_i.cnt - ert_pkg::CntW'(1);
  assign stale = entry_i.loaded && (entry_i.cnt < reload_i);

  always_comb begin
    entry_o = entry_i;
    emit_o = 1'b0;
    cmd_o = ert_pkg::CMD_RELEASE;
    unique case (req_type_i)
      ert_pkg::REQ_GET, ert_pkg::REQ_PIN: begin
        cmd_o = ert_pkg::CMD_LOAD;
        if (hit_i) begin
          emit_o = !entry_i.loaded;
          entry_o.loaded = 1'b1;
          entry_o.cnt = reload_i;
          if (req_type_i == ert_pkg::REQ_PIN) begin
            entry_o.pinned = 1'b1;
          end
        end
      end
      ert_pkg::REQ_TICK: begin
        if (entry_i.loaded && !entry_i.pinned) begin
          entry_o.cnt = dec;
          if (dec == '0) begin
            entry_o.loaded = 1'b0;
            emit_o = 1'b1;
          end
        end
      end
      ert_pkg::REQ_FLUSH_UNPINNED: begin
        if (stale && !entry_i.pinned) begin
          entry_o.loaded = 1'b0;
          emit_o = 1'b1;
        end
      end
      ert_pkg::REQ_FLUSH_PINNED: begin
        if (stale && entry_i.pinned) begin
          entry_o.loaded = 1'b0;
          entry_o.pinned = 1'b0;
          emit_o = 1'b1;
        end
      end
      ert_pkg::REQ_CLEAR: begin
        entry_o = '0;
      end
      ert_pkg::REQ_RELEASE_ALL: begin
        emit_o = entry_i.loaded;
      end
      default: begin
        emit_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/expiring_resident_table_unit.sv =====
// Expiring resident table: a ring of entry cells that rotates once per request.
// A request sweeps the full rotation of the cell ring and ends in a final beat that carries
// last; the ring holds while the result side stalls a found entry. One request is in work
// at a time: a new request is taken only when idle, after the last one loaded its final beat.
// Reset clears every entry at once and loads the reload register with 30.
`timescale 1ns / 1ps

module expiring_resident_table_unit #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ert_pkg::CntW-1:0]   cfg_wdata_i,
  ert_req_if.sink                    req_i,
  ert_rsp_if.source                  rsp_o
);

  localparam int unsigned StepW = $clog2(ENTRIES);
  localparam logic [StepW-1:0] LastStep = StepW'(ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_e;

  state_e                   state_q;
  logic [ert_pkg::ReqW-1:0] req_q;
  logic [ert_pkg::IdW-1:0]  id_q;
  logic [StepW-1:0]         step_q;
  logic [ert_pkg::CntW-1:0] reload_q;

  // Pending result: held back one find so the final beat of a sweep can carry last.
  logic                     pend_valid_q;
  logic [ert_pkg::CmdW-1:0] pend_cmd_q;
  logic [ert_pkg::IdW-1:0]  pend_id_q;

  logic                     out_valid_q;
  logic [ert_pkg::CmdW-1:0] out_cmd_q;
  logic [ert_pkg::IdW-1:0]  out_id_q;
  logic                     out_last_q;

  ert_pkg::entry_t          ring [ENTRIES];
  ert_pkg::entry_t          head_nxt;
  logic                     head_emit;
  logic [ert_pkg::CmdW-1:0] head_cmd;
  logic                     out_free;
  logic                     adv;
  logic                     shift;
  logic                     req_acc;
  logic                     out_load;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign adv = !(head_emit && pend_valid_q) || out_free;
  assign shift = (state_q == ST_SWEEP) && adv;
  assign req_acc = req_i.valid && req_i.ready;
  // The output register takes a new beat this cycle.
  assign out_load = (shift && head_emit && pend_valid_q) ||
                    ((state_q == ST_FINISH) && out_free);

  assign req_i.ready = (state_q == ST_IDLE);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.command = out_cmd_q;
  assign rsp_o.target_id = out_id_q;
  assign rsp_o.last = out_last_q;

  ert_head u_head (
    .entry_i    (ring[0]),
    .req_type_i (req_q),
    .hit_i      (id_q == ert_pkg::IdW'(step_q)),
    .reload_i   (reload_q),
    .entry_o    (head_nxt),
    .emit_o     (head_emit),
    .cmd_o      (head_cmd)
  );

  // Cell k takes the entry of cell k+1; the last cell takes the updated head entry.
  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    ert_pkg::entry_t cell_in;
    if (k == ENTRIES - 1) begin : g_tail
      assign cell_in = head_nxt;
    end else begin : g_mid
      assign cell_in = ring[k+1];
    end
    ert_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .entry_i (cell_in),
      .entry_o (ring[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= ert_pkg::ReloadRst;
    end else if (cfg_we_i) begin
      reload_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      req_q <= '0;
      id_q <= '0;
      step_q <= '0;
      pend_valid_q <= 1'b0;
      pend_cmd_q <= ert_pkg::CMD_ACK;
      pend_id_q <= '0;
      out_valid_q <= 1'b0;
      out_cmd_q <= ert_pkg::CMD_ACK;
      out_id_q <= '0;
      out_last_q <= 1'b0;
    end else begin
      if (rsp_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req_acc) begin
            req_q <= req_i.req_type;
            id_q <= req_i.entry_id;
            step_q <= '0;
            pend_valid_q <= 1'b0;
            state_q <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          if (adv) begin
            if (head_emit) begin
              if (pend_valid_q) begin
                out_valid_q <= 1'b1;
                out_cmd_q <= pend_cmd_q;
                out_id_q <= pend_id_q;
                out_last_q <= 1'b0;
              end
              pend_valid_q <= 1'b1;
              pend_cmd_q <= head_cmd;
              pend_id_q <= ert_pkg::IdW'(step_q);
            end
            if (step_q == LastStep) begin
              state_q <= ST_FINISH;
            end else begin
              step_q <= step_q + StepW'(1);
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_last_q <= 1'b1;
            out_cmd_q <= pend_valid_q ? pend_cmd_q : ert_pkg::CMD_ACK;
            out_id_q <= pend_valid_q ? pend_id_q : '0;
            pend_valid_q <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pend_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (state_q != ST_IDLE))
    else $error("pending result held while idle");

  a_accept_starts_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> (state_q == ST_SWEEP) && (step_q == '0))
    else $error("accepted request did not start a sweep at entry zero");

  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift && (step_q == LastStep) |=> (state_q == ST_FINISH))
    else $error("sweep did not finish after the last entry");

  a_ack_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_cmd_q == ert_pkg::CMD_ACK) |-> out_last_q && (out_id_q == '0))
    else $error("acknowledge beat without last or with nonzero target");

  a_no_stall_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) && head_emit && pend_valid_q && !out_free |=> $stable(step_q))
    else $error("ring advanced while a found entry had no room");
`endif

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for expiring_resident_table_unit: drives requests with random
// gaps, predicts every result beat from its own copy of the table, and checks them in order.
// Depends on ert_pkg and the ert_req_if / ert_rsp_if channel interfaces.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned ENTRIES = 64;
  localparam logic [ert_pkg::ReqW-1:0] REQ_UNUSED = 3'd7;
  localparam logic [ert_pkg::CntW-1:0] MaxReload = '1;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned ItemsPerPhase = 40;

  typedef struct packed {
    logic [ert_pkg::ReqW-1:0] kind;
    logic [ert_pkg::IdW-1:0]  id;
  } request_t;

  typedef struct packed {
    logic [ert_pkg::CmdW-1:0] command;
    logic [ert_pkg::IdW-1:0]  target_id;
    logic                     last;
  } beat_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [ert_pkg::CntW-1:0] cfg_wdata_i;

  ert_req_if req_if ();
  ert_rsp_if rsp_if ();

  expiring_resident_table_unit #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // Shadow copy of the table and its reload register.
  bit                     resident [ENTRIES];
  bit                     held [ENTRIES];
  bit [ert_pkg::CntW-1:0] ttl [ENTRIES];
  bit [ert_pkg::CntW-1:0] reload_q = ert_pkg::ReloadRst;

  request_t pending_reqs[$];
  beat_t    predicted_beats[$];
  request_t next_req;
  request_t taken_req;
  beat_t    want;

  int unsigned outstanding = 0;
  int unsigned req_gap = 0;
  int unsigned rsp_stall = 0;
  int unsigned mismatches = 0;
  int unsigned reqs_accepted = 0;
  int unsigned beats_seen = 0;
  int unsigned releases_seen = 0;
  int unsigned reload_writes = 0;
  bit          no_idle = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Applies one accepted request to the shadow table and queues the beats it must produce.
  task automatic table_apply(input request_t rq);
    int    released;
    bit    want_pinned;
    beat_t b;
    released = 0;
    want_pinned = (rq.kind == ert_pkg::REQ_FLUSH_PINNED);
    case (rq.kind)
      ert_pkg::REQ_GET, ert_pkg::REQ_PIN: begin
        b = '{ert_pkg::CMD_ACK, '0, 1'b1};
        if (rq.id < ENTRIES) begin
          if (rq.kind == ert_pkg::REQ_PIN) held[rq.id] = 1'b1;
          if (!resident[rq.id]) begin
            resident[rq.id] = 1'b1;
            b.command = ert_pkg::CMD_LOAD;
            b.target_id = rq.id;
          end
          ttl[rq.id] = reload_q;
        end
        predicted_beats.push_back(b);
        released = -1;
      end
      ert_pkg::REQ_TICK: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (resident[i] && !held[i]) begin
            ttl[i] = ttl[i] - 1'b1;
            if (ttl[i] == '0) begin
              resident[i] = 1'b0;
              predicted_beats.push_back('{ert_pkg::CMD_RELEASE, ert_pkg::IdW'(i), 1'b0});
              released++;
            end
          end
        end
      end
      ert_pkg::REQ_FLUSH_UNPINNED, ert_pkg::REQ_FLUSH_PINNED: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (resident[i] && (held[i] == want_pinned) && ttl[i] < reload_q) begin
            resident[i] = 1'b0;
            if (want_pinned) held[i] = 1'b0;
            predicted_beats.push_back('{ert_pkg::CMD_RELEASE, ert_pkg::IdW'(i), 1'b0});
            released++;
          end
        end
      end
      ert_pkg::REQ_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) begin
          resident[i] = 1'b0;
          held[i] = 1'b0;
          ttl[i] = '0;
        end
      end
      ert_pkg::REQ_RELEASE_ALL: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (resident[i]) begin
            predicted_beats.push_back('{ert_pkg::CMD_RELEASE, ert_pkg::IdW'(i), 1'b0});
            released++;
          end
        end
      end
      default: begin
      end
    endcase
    // A sweep that found nothing answers with a single acknowledge.
    if (released == 0) predicted_beats.push_back('{ert_pkg::CMD_ACK, '0, 1'b1});
    else if (released > 0) predicted_beats[predicted_beats.size() - 1].last = 1'b1;
  endtask

  task automatic queue_req(input logic [ert_pkg::ReqW-1:0] kind,
                           input logic [ert_pkg::IdW-1:0] id);
    pending_reqs.push_back('{kind, id});
    outstanding++;
  endtask

  task automatic wait_drained();
    while (outstanding != 0 || predicted_beats.size() != 0) @(posedge clk_i);
    repeat (ENTRIES + 4) @(posedge clk_i);
  endtask

  task automatic set_reload(input logic [ert_pkg::CntW-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reload_q = value;
    reload_writes++;
  endtask

  // Request driver: holds each beat until it is taken, then waits out a random gap.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        taken_req.kind = req_if.req_type;
        taken_req.id = req_if.entry_id;
        table_apply(taken_req);
        outstanding--;
        reqs_accepted++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (req_gap > 0) begin
          req_gap--;
          req_if.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          next_req = pending_reqs.pop_front();
          req_if.valid <= 1'b1;
          req_if.req_type <= next_req.kind;
          req_if.entry_id <= next_req.id;
          req_gap = pick_gap();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted beat against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        beats_seen++;
        if (rsp_if.command == ert_pkg::CMD_RELEASE) releases_seen++;
        if (predicted_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected beat: cmd %0d id %0d last %0b", rsp_if.command,
                     rsp_if.target_id, rsp_if.last);
        end else begin
          want = predicted_beats.pop_front();
          if (rsp_if.command !== want.command || rsp_if.target_id !== want.target_id ||
              rsp_if.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Beat %0d: expected cmd %0d id %0d last %0b, got cmd %0d id %0d last %0b",
                       beats_seen, want.command, want.target_id, want.last,
                       rsp_if.command, rsp_if.target_id, rsp_if.last);
          end
        end
      end
      if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) rsp_stall = pick_gap();
      end
    end
  end

  initial begin
    int unsigned r;
    logic [ert_pkg::IdW-1:0] id;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    req_if.valid = 1'b0;
    req_if.req_type = ert_pkg::REQ_GET;
    req_if.entry_id = '0;
    rsp_if.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset reload: miss, hit, both ends of the id range, pinning, each sweep, clear.
    queue_req(ert_pkg::REQ_GET, 6'd0);
    queue_req(ert_pkg::REQ_GET, 6'd0);
    queue_req(ert_pkg::REQ_GET, 6'd63);
    queue_req(ert_pkg::REQ_PIN, 6'd5);
    queue_req(ert_pkg::REQ_PIN, 6'd0);
    queue_req(ert_pkg::REQ_TICK, 6'd63);
    queue_req(ert_pkg::REQ_FLUSH_UNPINNED, 6'd0);
    queue_req(ert_pkg::REQ_FLUSH_PINNED, 6'd0);
    queue_req(ert_pkg::REQ_RELEASE_ALL, 6'd0);
    queue_req(REQ_UNUSED, 6'd63);
    queue_req(ert_pkg::REQ_CLEAR, 6'd0);
    queue_req(ert_pkg::REQ_RELEASE_ALL, 6'd0);
    wait_drained();

    // Reload of one: a single tick expires every unpinned entry.
    set_reload(15'd1);
    queue_req(ert_pkg::REQ_GET, 6'd10);
    queue_req(ert_pkg::REQ_GET, 6'd20);
    queue_req(ert_pkg::REQ_PIN, 6'd30);
    queue_req(ert_pkg::REQ_TICK, 6'd0);
    queue_req(ert_pkg::REQ_RELEASE_ALL, 6'd0);
    wait_drained();

    // Entries loaded under a short reload become stale once the reload is raised to the top.
    set_reload(15'd2);
    queue_req(ert_pkg::REQ_GET, 6'd40);
    queue_req(ert_pkg::REQ_PIN, 6'd41);
    wait_drained();
    set_reload(MaxReload);
    queue_req(ert_pkg::REQ_FLUSH_PINNED, 6'd0);
    queue_req(ert_pkg::REQ_FLUSH_UNPINNED, 6'd0);
    wait_drained();

    // Zero reload: the tick wraps the countdown instead of releasing the entry.
    set_reload('0);
    queue_req(ert_pkg::REQ_GET, 6'd7);
    queue_req(ert_pkg::REQ_TICK, 6'd0);
    queue_req(ert_pkg::REQ_FLUSH_UNPINNED, 6'd0);
    queue_req(ert_pkg::REQ_GET, 6'd7);
    wait_drained();

    for (int p = 0; p < RandomPhases; p++) begin
      if (p == 0) set_reload(MaxReload);
      else if (p == 3) set_reload(ert_pkg::ReloadRst);
      else if (p == 5) set_reload('0);
      else set_reload(ert_pkg::CntW'($urandom_range(1, 6)));
      no_idle = (p % 4 == 2);
      for (int k = 0; k < ItemsPerPhase; k++) begin
        r = $urandom_range(0, 99);
        // Half the ids come from a small set so that hits and re-pins are common.
        id = $urandom_range(0, 1) ? ert_pkg::IdW'($urandom_range(0, 63))
                                  : ert_pkg::IdW'($urandom_range(0, 7));
        if (r < 40) queue_req(ert_pkg::REQ_GET, id);
        else if (r < 50) queue_req(ert_pkg::REQ_PIN, id);
        else if (r < 75) queue_req(ert_pkg::REQ_TICK, id);
        else if (r < 83) queue_req(ert_pkg::REQ_FLUSH_UNPINNED, id);
        else if (r < 90) queue_req(ert_pkg::REQ_FLUSH_PINNED, id);
        else if (r < 95) queue_req(ert_pkg::REQ_RELEASE_ALL, id);
        else if (r < 98) queue_req(ert_pkg::REQ_CLEAR, id);
        else queue_req(REQ_UNUSED, id);
      end
      wait_drained();
    end
    no_idle = 1'b0;

    $display("Sent %0d requests under %0d reload settings; checked %0d result beats.",
             reqs_accepted, reload_writes, beats_seen);
    $display("Release beats seen: %0d, mismatches: %0d.", releases_seen, mismatches);
    if (mismatches == 0 && predicted_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Timeout: %0d predicted beats still outstanding.", predicted_beats.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
src/ert_pkg.sv
src/ert_req_if.sv
src/ert_rsp_if.sv
src/ert_cell.sv
src/ert_head.sv
src/expiring_resident_table_unit.sv
dv/tb.sv
